[rtl/core/emrt_pkg.sv]
// shared types and constants for the exact-match route table
package emrt_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int MODE_W      = 3;
	localparam int ADDR_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 5;
	localparam int FIFO_DEPTH  = 4;

	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_UPDATE = 3'd2,
		OP_FIND   = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_NOP    = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EXISTS    = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] hop;
	} req_t;

endpackage

[rtl/core/emrt_if.sv]
// request and response channel interfaces of the route table
interface emrt_req_if import emrt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ADDR_W-1:0] dest_addr;
	logic [ADDR_W-1:0] hop_addr;

	modport source (output valid, mode, dest_addr, hop_addr, input ready);
	modport sink (input valid, mode, dest_addr, hop_addr, output ready);
endinterface

interface emrt_rsp_if import emrt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [ADDR_W-1:0]   found_hop;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, status, found, found_hop, count, input ready);
	modport sink (input valid, status, found, found_hop, count, output ready);
endinterface

[rtl/core/emrt_front.sv]
// request intake: decodes the mode into an operation and feeds the queue
module emrt_front import emrt_pkg::*; (
	input  logic        init_done,
	emrt_req_if.sink    req,
	input  logic        q_full,
	output logic        q_push,
	output req_t        q_data
);

	op_t op;

	always_comb begin
		unique case (req.mode)
			MODE_ADD:    op = OP_ADD;
			MODE_REMOVE: op = OP_REMOVE;
			MODE_UPDATE: op = OP_UPDATE;
			MODE_FIND:   op = OP_FIND;
			MODE_CLEAR:  op = OP_CLEAR;
			default:     op = OP_NOP;
		endcase
	end

	// no transaction until the table has been swept after reset
	assign req.ready   = init_done && !q_full;
	assign q_push      = req.valid && req.ready;
	assign q_data.op   = op;
	assign q_data.dest = req.dest_addr;
	assign q_data.hop  = req.hop_addr;

endmodule

[rtl/core/emrt_fifo.sv]
// short request queue between intake and table engine
module emrt_fifo import emrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t wdata,
	output logic full,
	input  logic pop,
	output req_t rdata,
	output logic empty
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	req_t             store_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == CNT_W'(FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/core/emrt_engine.sv]
// table engine: entry memory, sequential scan, write-back and response register
module emrt_engine import emrt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  req_t       q_data,
	output logic       q_pop,
	output logic       init_done,
	emrt_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef struct packed {
		logic              vld;
		logic [ADDR_W-1:0] key;
		logic [ADDR_W-1:0] hop;
	} entry_t;

	typedef enum logic [3:0] {
		S_SWEEP = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_EXEC  = 4'b1000
	} state_t;

	entry_t             mem [ENTRIES];
	entry_t             rd_data_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               rd_vld_s1;

	state_t             state_q;
	req_t               cur_q;
	logic [IDX_W-1:0]   iss_q;
	logic               iss_done_q;
	logic [IDX_W-1:0]   sweep_q;
	logic               hit_q;
	logic [IDX_W-1:0]   slot_q;
	logic [ADDR_W-1:0]  hop_q;
	logic               free_vld_q;
	logic [IDX_W-1:0]   free_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               init_done_q;

	logic               ovalid_q;
	status_t            ostatus_q;
	logic               ofound_q;
	logic [ADDR_W-1:0]  ohop_q;
	logic [COUNT_W-1:0] ocount_q;

	logic               scan_issue;
	logic               entry_match;
	logic               first_free;
	logic               scan_end;
	logic               out_free;
	logic               exec_go;
	logic               take;

	status_t            res_status;
	logic               res_found;
	logic [ADDR_W-1:0]  res_hop;
	logic [CNT_W-1:0]   cnt_nxt;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	entry_t             mem_wdata;

	assign entry_match = rd_vld_s1 && rd_data_s1.vld && (rd_data_s1.key == cur_q.dest);
	assign first_free  = rd_vld_s1 && !rd_data_s1.vld && !free_vld_q;
	// keys are unique, so the scan can stop at the first hit
	assign scan_end    = rd_vld_s1 && (entry_match || rd_idx_s1 == LAST_IDX);
	assign scan_issue  = (state_q == S_SCAN) && !iss_done_q && !scan_end;
	assign out_free    = !ovalid_q || rsp.ready;
	assign exec_go     = (state_q == S_EXEC) && out_free;
	assign take        = (state_q == S_IDLE) && !q_empty;
	assign q_pop       = take;
	assign init_done   = init_done_q;

	always_comb begin
		res_status = STAT_OK;
		res_found  = 1'b0;
		res_hop    = '0;
		cnt_nxt    = cnt_q;
		mem_we     = 1'b0;
		mem_waddr  = slot_q;
		mem_wdata  = '{vld: 1'b1, key: cur_q.dest, hop: cur_q.hop};
		if (state_q == S_SWEEP) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_q;
			mem_wdata = '0;
		end else if (exec_go) begin
			unique case (cur_q.op)
				OP_ADD: begin
					if (hit_q) begin
						res_status = STAT_EXISTS;
						res_found  = 1'b1;
						res_hop    = hop_q;
					end else if (free_vld_q) begin
						mem_we    = 1'b1;
						mem_waddr = free_q;
						cnt_nxt   = cnt_q + CNT_W'(1);
					end else begin
						res_status = STAT_FULL;
					end
				end
				OP_REMOVE: begin
					if (hit_q) begin
						res_found     = 1'b1;
						res_hop       = hop_q;
						mem_we        = 1'b1;
						mem_wdata.vld = 1'b0;
						cnt_nxt       = cnt_q - CNT_W'(1);
					end else begin
						res_status = STAT_NOT_FOUND;
					end
				end
				OP_UPDATE: begin
					if (hit_q) begin
						res_found = 1'b1;
						res_hop   = cur_q.hop;
						mem_we    = 1'b1;
					end else begin
						res_status = STAT_NOT_FOUND;
					end
				end
				OP_FIND: begin
					if (hit_q) begin
						res_found = 1'b1;
						res_hop   = hop_q;
					end else begin
						res_status = STAT_NOT_FOUND;
					end
				end
				OP_CLEAR: begin
					cnt_nxt = '0;
				end
				OP_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_nxt};

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (scan_issue) begin
			rd_data_s1 <= mem[iss_q];
			rd_idx_s1  <= iss_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			init_done_q <= 1'b0;
			iss_q       <= '0;
			iss_done_q  <= 1'b0;
			hit_q       <= 1'b0;
			free_vld_q  <= 1'b0;
			cnt_q       <= '0;
			ovalid_q    <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (exec_go) begin
				ovalid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					if (sweep_q == LAST_IDX) begin
						sweep_q     <= '0;
						init_done_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (take) begin
						hit_q      <= 1'b0;
						free_vld_q <= 1'b0;
						iss_q      <= '0;
						iss_done_q <= 1'b0;
						if (q_data.op == OP_CLEAR || q_data.op == OP_NOP) begin
							state_q <= S_EXEC;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						if (iss_q == LAST_IDX) begin
							iss_done_q <= 1'b1;
						end else begin
							iss_q <= iss_q + IDX_W'(1);
						end
					end
					if (entry_match) begin
						hit_q <= 1'b1;
					end
					if (first_free) begin
						free_vld_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						cnt_q    <= cnt_nxt;
						state_q  <= (cur_q.op == OP_CLEAR) ? S_SWEEP : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_data;
		end
		if (entry_match) begin
			slot_q <= rd_idx_s1;
			hop_q  <= rd_data_s1.hop;
		end
		if (first_free) begin
			free_q <= rd_idx_s1;
		end
		if (exec_go) begin
			ostatus_q <= res_status;
			ofound_q  <= res_found;
			ohop_q    <= res_hop;
			ocount_q  <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign rsp.valid     = ovalid_q;
	assign rsp.status    = ostatus_q;
	assign rsp.found     = ofound_q;
	assign rsp.found_hop = ohop_q;
	assign rsp.count     = ocount_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("entry count above table size");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == S_SCAN))
		else $error("memory read data outside a scan");

	a_hit_needs_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && hit_q) |-> (cur_q.op != OP_CLEAR && cur_q.op != OP_NOP))
		else $error("hit recorded for an operation that does not scan");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && ofound_q) |-> (ostatus_q == STAT_OK || ostatus_q == STAT_EXISTS))
		else $error("hit reported with a miss status");

endmodule

[rtl/core/exact_match_route_table_unit.sv]
// exact-match route table: intake, request queue and table engine
//
// req carries one transaction per operation (add, remove, update, find,
// clear all; other mode codes do nothing) keyed by a 32-bit destination.
// rsp returns exactly one transaction per request, in order, with status,
// hit flag, next hop and the entry count after the operation.
// After reset the entry memory is swept, one entry per cycle; req.ready
// stays low until the sweep is done.
// Add, remove, update and find scan the entry memory one entry per cycle
// through its single read port and stop at the first hit. A clear skips
// the scan, answers and then sweeps the memory before the next request
// starts. The engine works on one request at a time.
// A four-deep queue keeps taking requests while the engine works or while
// rsp is stalled; the response register holds its transaction until
// rsp.ready, and the engine waits for it before finishing the next request.
module exact_match_route_table_unit import emrt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	emrt_req_if.sink   req,
	emrt_rsp_if.source rsp
);

	logic init_done;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	req_t q_wdata;
	req_t q_rdata;

	emrt_front u_front (
		.init_done (init_done),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	emrt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	emrt_engine #(
		.ENTRIES (ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.init_done (init_done),
		.rsp       (rsp)
	);

endmodule
